### src/blkc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package blkc_pkg;

   // held mask covers only the low slots
   localparam int HELD_W = 16;
   localparam int TAG_W = 64;
   localparam int ADDR_W = 32;
   localparam int SLOT_OUT_W = 4;

   // csr word index for the base address register
   localparam logic CSR_BASE_IDX = 1'b0;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } blkc_state_type;

   // scan record flags handed from cell to cell
   typedef struct packed {
      logic active;
      logic hit;
      logic have_free;
      logic have_victim;
   } scan_flags_type;

   // table update request broadcast to all cells
   typedef struct packed {
      logic en;
      logic alloc;
   } update_ctrl_type;

endpackage
`default_nettype wire

### src/block_cache_lru_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative block cache directory with least-recently-used replacement. Each slot
// lives in a cell of a chain; a request's scan record walks the chain one cell per clock,
// collecting a tag hit, the first empty slot and the oldest unheld slot, and the controller
// then writes the new stamp (and tag on allocation) at the edge that loads the result. A
// request passes from acceptance through the start register, every cell of the chain and the
// finish state to the result register. The next request is taken the cycle after the result
// is loaded, even if the result still waits, so a request is not taken before the previous
// one has been loaded; a result that still waits holds back the load of the next one. When a
// miss finds every slot held, no_slot is reported and the table and use counter stay
// unchanged. The base address register sits at byte offset 0 of the configuration port.
module block_cache_lru_lookup #(
   parameter int SLOTS = 16,
   parameter int BLOCK_BYTES = 512,
   parameter int STAMP_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [blkc_pkg::TAG_W-1:0]       req_block_number,
   input  wire logic [blkc_pkg::HELD_W-1:0]      req_held_mask,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_hit,
   output logic [blkc_pkg::SLOT_OUT_W-1:0]       rsp_slot_index,
   output logic [blkc_pkg::ADDR_W-1:0]           rsp_block_address,
   output logic                                  rsp_no_slot,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [2:0]                       paddr,
   input  wire logic [31:0]                      pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   localparam int IDX_W = $clog2(SLOTS);

   logic [blkc_pkg::ADDR_W-1:0] base_ff;
   logic [blkc_pkg::TAG_W-1:0]  key_tag;
   logic [blkc_pkg::HELD_W-1:0] held_mask;

   blkc_pkg::scan_flags_type    chain_flags [SLOTS+1];
   logic [IDX_W-1:0]            chain_hit_idx [SLOTS+1];
   logic [IDX_W-1:0]            chain_free_idx [SLOTS+1];
   logic [IDX_W-1:0]            chain_victim_idx [SLOTS+1];
   logic [STAMP_BITS-1:0]       chain_victim_stamp [SLOTS+1];

   blkc_pkg::update_ctrl_type   upd;
   logic [IDX_W-1:0]            upd_idx;
   logic [STAMP_BITS-1:0]       upd_stamp;

   // configuration register
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (psel && penable && pwrite && pready && paddr[2] == blkc_pkg::CSR_BASE_IDX) begin
         base_ff <= pwdata;
      end
   end

   assign prdata = (paddr[2] == blkc_pkg::CSR_BASE_IDX) ? base_ff : '0;

   // sequencing, counter and result register
   blkc_ctrl #(
      .IDX_W(IDX_W),
      .STAMP_BITS(STAMP_BITS),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_block_number(req_block_number),
      .req_held_mask(req_held_mask),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_slot_index(rsp_slot_index),
      .rsp_block_address(rsp_block_address),
      .rsp_no_slot(rsp_no_slot),
      .base_address(base_ff),
      .key_tag(key_tag),
      .held_mask(held_mask),
      .scan_start(chain_flags[0]),
      .scan_end_flags(chain_flags[SLOTS]),
      .scan_end_hit_idx(chain_hit_idx[SLOTS]),
      .scan_end_free_idx(chain_free_idx[SLOTS]),
      .scan_end_victim_idx(chain_victim_idx[SLOTS]),
      .upd(upd),
      .upd_idx(upd_idx),
      .upd_stamp(upd_stamp)
   );

   // empty scan record entering the first cell
   assign chain_hit_idx[0] = '0;
   assign chain_free_idx[0] = '0;
   assign chain_victim_idx[0] = '0;
   assign chain_victim_stamp[0] = '0;

   // chain of slot cells
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic held;
      if (i < blkc_pkg::HELD_W) begin : g_held
         assign held = held_mask[i];
      end else begin : g_free
         assign held = 1'b0;
      end

      blkc_cell #(
         .IDX_W(IDX_W),
         .STAMP_BITS(STAMP_BITS),
         .CELL_INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .key_tag(key_tag),
         .held(held),
         .scan_in_flags(chain_flags[i]),
         .scan_in_hit_idx(chain_hit_idx[i]),
         .scan_in_free_idx(chain_free_idx[i]),
         .scan_in_victim_idx(chain_victim_idx[i]),
         .scan_in_victim_stamp(chain_victim_stamp[i]),
         .scan_out_flags(chain_flags[i+1]),
         .scan_out_hit_idx(chain_hit_idx[i+1]),
         .scan_out_free_idx(chain_free_idx[i+1]),
         .scan_out_victim_idx(chain_victim_idx[i+1]),
         .scan_out_victim_stamp(chain_victim_stamp[i+1]),
         .upd(upd),
         .upd_idx(upd_idx),
         .upd_stamp(upd_stamp)
      );
   end

endmodule
`default_nettype wire

### src/blkc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module blkc_cell #(
   parameter int IDX_W = 4,
   parameter int STAMP_BITS = 32,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [blkc_pkg::TAG_W-1:0]   key_tag,
   input  wire logic                         held,
   input  wire blkc_pkg::scan_flags_type     scan_in_flags,
   input  wire logic [IDX_W-1:0]             scan_in_hit_idx,
   input  wire logic [IDX_W-1:0]             scan_in_free_idx,
   input  wire logic [IDX_W-1:0]             scan_in_victim_idx,
   input  wire logic [STAMP_BITS-1:0]        scan_in_victim_stamp,
   output blkc_pkg::scan_flags_type          scan_out_flags,
   output logic [IDX_W-1:0]                  scan_out_hit_idx,
   output logic [IDX_W-1:0]                  scan_out_free_idx,
   output logic [IDX_W-1:0]                  scan_out_victim_idx,
   output logic [STAMP_BITS-1:0]             scan_out_victim_stamp,
   input  wire blkc_pkg::update_ctrl_type    upd,
   input  wire logic [IDX_W-1:0]             upd_idx,
   input  wire logic [STAMP_BITS-1:0]        upd_stamp
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                      valid_ff;
   logic [blkc_pkg::TAG_W-1:0] tag_ff;
   logic [STAMP_BITS-1:0]     stamp_ff;

   blkc_pkg::scan_flags_type  flags_ff, flags_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]          victim_idx_ff, victim_idx_in;
   logic [STAMP_BITS-1:0]     victim_stamp_ff, victim_stamp_in;

   logic                      my_upd;

   // examine this slot against the passing scan record
   always_comb begin
      flags_in = scan_in_flags;
      hit_idx_in = scan_in_hit_idx;
      free_idx_in = scan_in_free_idx;
      victim_idx_in = scan_in_victim_idx;
      victim_stamp_in = scan_in_victim_stamp;
      if (!scan_in_flags.hit) begin
         if (valid_ff && tag_ff == key_tag) begin
            flags_in.hit = 1'b1;
            hit_idx_in = MY_IDX;
         end else if (!valid_ff) begin
            if (!scan_in_flags.have_free) begin
               flags_in.have_free = 1'b1;
               free_idx_in = MY_IDX;
            end
         end else if (!held) begin
            if (!scan_in_flags.have_victim || scan_in_victim_stamp > stamp_ff) begin
               flags_in.have_victim = 1'b1;
               victim_idx_in = MY_IDX;
               victim_stamp_in = stamp_ff;
            end
         end
      end
   end

   // scan record register toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (scan_in_flags.active) begin
         flags_ff <= flags_in;
      end else begin
         flags_ff.active <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_in_flags.active) begin
         hit_idx_ff <= hit_idx_in;
         free_idx_ff <= free_idx_in;
         victim_idx_ff <= victim_idx_in;
         victim_stamp_ff <= victim_stamp_in;
      end
   end

   // slot contents
   assign my_upd = upd.en && upd_idx == MY_IDX;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (my_upd && upd.alloc) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (my_upd) begin
         stamp_ff <= upd_stamp;
         if (upd.alloc) begin
            tag_ff <= key_tag;
         end
      end
   end

   assign scan_out_flags = flags_ff;
   assign scan_out_hit_idx = hit_idx_ff;
   assign scan_out_free_idx = free_idx_ff;
   assign scan_out_victim_idx = victim_idx_ff;
   assign scan_out_victim_stamp = victim_stamp_ff;

endmodule
`default_nettype wire

### src/blkc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module blkc_ctrl #(
   parameter int IDX_W = 4,
   parameter int STAMP_BITS = 32,
   parameter int BLOCK_BYTES = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [blkc_pkg::TAG_W-1:0]       req_block_number,
   input  wire logic [blkc_pkg::HELD_W-1:0]      req_held_mask,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_hit,
   output logic [blkc_pkg::SLOT_OUT_W-1:0]       rsp_slot_index,
   output logic [blkc_pkg::ADDR_W-1:0]           rsp_block_address,
   output logic                                  rsp_no_slot,
   input  wire logic [blkc_pkg::ADDR_W-1:0]      base_address,
   output logic [blkc_pkg::TAG_W-1:0]            key_tag,
   output logic [blkc_pkg::HELD_W-1:0]           held_mask,
   output blkc_pkg::scan_flags_type              scan_start,
   input  wire blkc_pkg::scan_flags_type         scan_end_flags,
   input  wire logic [IDX_W-1:0]                 scan_end_hit_idx,
   input  wire logic [IDX_W-1:0]                 scan_end_free_idx,
   input  wire logic [IDX_W-1:0]                 scan_end_victim_idx,
   output blkc_pkg::update_ctrl_type             upd,
   output logic [IDX_W-1:0]                      upd_idx,
   output logic [STAMP_BITS-1:0]                 upd_stamp
);

   blkc_pkg::blkc_state_type state_ff, state_in;

   logic [blkc_pkg::TAG_W-1:0]  key_ff;
   logic [blkc_pkg::HELD_W-1:0] held_ff;
   logic                        start_ff;
   logic [STAMP_BITS-1:0]       counter_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [blkc_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [blkc_pkg::ADDR_W-1:0] rsp_addr_ff;
   logic                        rsp_no_slot_ff;

   logic                        accept;
   logic                        load;
   logic                        found;
   logic [IDX_W-1:0]            chosen;
   logic [blkc_pkg::ADDR_W-1:0] slot_offset;

   // slot picked from the finished scan record
   assign found = scan_end_flags.hit || scan_end_flags.have_free || scan_end_flags.have_victim;
   assign chosen = scan_end_flags.hit       ? scan_end_hit_idx :
                   scan_end_flags.have_free ? scan_end_free_idx : scan_end_victim_idx;
   assign slot_offset = blkc_pkg::ADDR_W'(chosen) * blkc_pkg::ADDR_W'(BLOCK_BYTES);

   // next state and handshake
   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      load = 1'b0;
      upd = '0;
      unique case (state_ff)
         blkc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = blkc_pkg::ST_SCAN;
            end
         end
         blkc_pkg::ST_SCAN: begin
            if (scan_end_flags.active) begin
               state_in = blkc_pkg::ST_FINISH;
            end
         end
         blkc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               state_in = blkc_pkg::ST_IDLE;
               upd.en = found;
               upd.alloc = !scan_end_flags.hit;
            end
         end
         default: begin
            state_in = blkc_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blkc_pkg::ST_IDLE;
         start_ff <= 1'b0;
         counter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept;
         if (upd.en) begin
            counter_ff <= counter_ff + 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_block_number;
         held_ff <= req_held_mask;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_no_slot_ff <= !found;
         rsp_hit_ff <= found && scan_end_flags.hit;
         rsp_slot_ff <= found ? blkc_pkg::SLOT_OUT_W'(chosen) : '0;
         rsp_addr_ff <= found ? base_address + slot_offset : '0;
      end
   end

   always_comb begin
      scan_start = '0;
      scan_start.active = start_ff;
   end

   assign key_tag = key_ff;
   assign held_mask = held_ff;
   assign upd_idx = chosen;
   assign upd_stamp = counter_ff + 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_no_slot = rsp_no_slot_ff;

endmodule
`default_nettype wire
